### hdl/fit_policy_block_allocator_defines.svh
// Assertion macros shared by the allocator checker.
// No dependencies; include by bare file name.
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define FPBA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define FPBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/fpba_pkg.sv
// Shared codes and types for the fit-policy block allocator.
// No dependencies; used by the top level, the checker and the testbench.
package fpba_pkg;

   localparam int SIZE_W     = 16;
   localparam int OUT_IDX_W  = 5;

   // Item function codes
   localparam logic [1:0] FUNC_LOAD    = 2'd0;
   localparam logic [1:0] FUNC_REQUEST = 2'd1;
   localparam logic [1:0] FUNC_CLEAR   = 2'd2;

   // Result status codes
   localparam logic [1:0] STATUS_DONE   = 2'd0;
   localparam logic [1:0] STATUS_NO_FIT = 2'd1;
   localparam logic [1:0] STATUS_FULL   = 2'd2;

   // Placement policies; the unused code behaves as first fit
   localparam logic [1:0] POLICY_FIRST = 2'd0;
   localparam logic [1:0] POLICY_BEST  = 2'd1;
   localparam logic [1:0] POLICY_WORST = 2'd2;

   // One table entry as stored in memory
   typedef struct packed {
      logic              used;
      logic [SIZE_W-1:0] size;
   } entry_type;

endpackage

### hdl/fpba_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module fpba_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/fit_policy_block_allocator.sv
// Fit-policy block allocator: table control, scan and result register.
// Depends on fpba_pkg and fpba_ram.

// Holds a table of up to MAX_BLOCKS block sizes in one synchronous RAM, each
// entry tagged with a used flag. A load appends a block, a request places a
// size in an unused block chosen by the csr_fit_policy rule (first, best or
// worst fit, ties to the lower index), a clear empties the table. Load,
// clear and the unused function code return their result in the cycle after
// the transfer. A request reads the table one entry per cycle through the
// single RAM read port in the scan state, then writes back the chosen entry
// and posts the result from the update state. One item is worked at a time;
// a new item is taken once the block is idle and the result register is
// free or being drained.
// No clearing pass is needed after reset: only entries below the block count
// are read, and each of those was written by a load.
module fit_policy_block_allocator #(
   parameter int MAX_BLOCKS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_fit_policy,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [15:0] req_size_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [4:0]  rsp_block_index,
   output logic [15:0] rsp_leftover
);

   localparam int IDX_W   = $clog2(MAX_BLOCKS);
   localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
   localparam int ENTRY_W = $bits(fpba_pkg::entry_type);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_UPDATE} state_type;

   state_type                     state_ff, state_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [1:0]                    policy_ff, policy_in;
   logic [fpba_pkg::SIZE_W-1:0]   size_ff, size_in;
   logic [CNT_W-1:0]              rd_cnt_ff, rd_cnt_in;
   logic                          cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]              cmp_idx_ff, cmp_idx_in;
   logic                          found_ff, found_in;
   logic [IDX_W-1:0]              pick_ff, pick_in;
   logic [fpba_pkg::SIZE_W-1:0]   pick_size_ff, pick_size_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [1:0]                    rsp_status_ff, rsp_status_in;
   logic [4:0]                    rsp_index_ff, rsp_index_in;
   logic [fpba_pkg::SIZE_W-1:0]   rsp_leftover_ff, rsp_leftover_in;

   logic                          out_free;
   logic                          table_full;
   logic                          take;
   logic                          wr_en;
   logic [IDX_W-1:0]              wr_addr;
   fpba_pkg::entry_type           wr_entry;
   logic                          rd_en;
   logic [ENTRY_W-1:0]            rd_word;
   fpba_pkg::entry_type           rd_entry;
   logic [IDX_W+4:0]              count_ext;
   logic [IDX_W+4:0]              pick_ext;
   logic [fpba_pkg::SIZE_W-1:0]   left_size;

   // Block size table with used flags
   fpba_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_BLOCKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_cnt_ff[IDX_W-1:0]),
      .rd_data (rd_word)
   );

   assign rd_entry   = fpba_pkg::entry_type'(rd_word);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign table_full = (count_ff == CNT_W'(MAX_BLOCKS));
   assign count_ext  = {5'd0, count_ff[IDX_W-1:0]};
   assign pick_ext   = {5'd0, pick_ff};
   assign left_size  = pick_size_ff - size_ff;

   // Decide whether the entry just read replaces the current pick
   always_comb begin
      take = 1'b0;
      if (cmp_vld_ff && !rd_entry.used && (rd_entry.size >= size_ff)) begin
         if (!found_ff) begin
            take = 1'b1;
         end else if (policy_ff == fpba_pkg::POLICY_BEST) begin
            take = (rd_entry.size < pick_size_ff);
         end else if (policy_ff == fpba_pkg::POLICY_WORST) begin
            take = (rd_entry.size > pick_size_ff);
         end
      end
   end

   // Next-state logic for control, scan and result register
   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      policy_in       = policy_ff;
      size_in         = size_ff;
      rd_cnt_in       = rd_cnt_ff;
      cmp_vld_in      = 1'b0;
      cmp_idx_in      = rd_cnt_ff[IDX_W-1:0];
      found_in        = found_ff;
      pick_in         = pick_ff;
      pick_size_in    = pick_size_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_index_in    = rsp_index_ff;
      rsp_leftover_in = rsp_leftover_ff;
      wr_en           = 1'b0;
      wr_addr         = count_ff[IDX_W-1:0];
      wr_entry        = '0;
      rd_en           = 1'b0;

      // Drop the result once it is taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid) begin
         policy_in = csr_fit_policy;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && out_free) begin
               size_in         = req_size_value;
               rd_cnt_in       = '0;
               found_in        = 1'b0;
               pick_in         = '0;
               pick_size_in    = '0;
               rsp_status_in   = fpba_pkg::STATUS_DONE;
               rsp_index_in    = '0;
               rsp_leftover_in = '0;
               case (req_func)
                  fpba_pkg::FUNC_LOAD: begin
                     rsp_valid_in = 1'b1;
                     if (table_full) begin
                        rsp_status_in = fpba_pkg::STATUS_FULL;
                     end else begin
                        wr_en         = 1'b1;
                        wr_entry.used = 1'b0;
                        wr_entry.size = req_size_value;
                        rsp_index_in  = count_ext[4:0];
                        count_in      = count_ff + CNT_W'(1);
                     end
                  end
                  fpba_pkg::FUNC_REQUEST: begin
                     state_in = ST_SCAN;
                  end
                  fpba_pkg::FUNC_CLEAR: begin
                     rsp_valid_in = 1'b1;
                     count_in     = '0;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // Issue one read per cycle and compare its data in the cycle after
            if (rd_cnt_ff != count_ff) begin
               rd_en      = 1'b1;
               rd_cnt_in  = rd_cnt_ff + CNT_W'(1);
               cmp_vld_in = 1'b1;
            end
            if (take) begin
               found_in     = 1'b1;
               pick_in      = cmp_idx_ff;
               pick_size_in = rd_entry.size;
            end
            if ((rd_cnt_ff == count_ff) && !cmp_vld_ff) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // Write back the chosen entry and post the result
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (found_ff) begin
                  wr_en           = 1'b1;
                  wr_addr         = pick_ff;
                  wr_entry.used   = 1'b1;
                  wr_entry.size   = left_size;
                  rsp_status_in   = fpba_pkg::STATUS_DONE;
                  rsp_index_in    = pick_ext[4:0];
                  rsp_leftover_in = left_size;
               end else begin
                  rsp_status_in   = fpba_pkg::STATUS_NO_FIT;
                  rsp_index_in    = '0;
                  rsp_leftover_in = '0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         policy_ff    <= fpba_pkg::POLICY_FIRST;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         policy_ff    <= policy_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      size_ff         <= size_in;
      rd_cnt_ff       <= rd_cnt_in;
      cmp_idx_ff      <= cmp_idx_in;
      found_ff        <= found_in;
      pick_ff         <= pick_in;
      pick_size_ff    <= pick_size_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_index_ff    <= rsp_index_in;
      rsp_leftover_ff <= rsp_leftover_in;
   end

   assign csr_ready       = 1'b1;
   assign req_ready       = (state_ff == ST_IDLE) && out_free;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_block_index = rsp_index_ff;
   assign rsp_leftover    = rsp_leftover_ff;

endmodule

### hdl/fpba_checker.sv
// Port-level checker for the fit-policy block allocator, bound to the top level.
// Depends on fpba_pkg and fit_policy_block_allocator_defines.svh.
`include "fit_policy_block_allocator_defines.svh"

module fpba_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_func,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [4:0]  rsp_block_index,
   input logic [15:0] rsp_leftover
);

   logic        rsp_stall;
   logic [22:0] rsp_payload;
   logic        rsp_fail;
   logic        status_known;
   logic        rsp_zero;
   logic        clear_xfer;
   logic        clear_ok;

   // Condense the result channel into a few terms
   assign rsp_stall    = rsp_valid && !rsp_ready;
   assign rsp_payload  = {rsp_status, rsp_block_index, rsp_leftover};
   assign rsp_fail     = rsp_valid && (rsp_status != fpba_pkg::STATUS_DONE);
   assign status_known = (rsp_status == fpba_pkg::STATUS_DONE) ||
                         (rsp_status == fpba_pkg::STATUS_NO_FIT) ||
                         (rsp_status == fpba_pkg::STATUS_FULL);
   assign rsp_zero     = (rsp_block_index == 5'd0) && (rsp_leftover == 16'd0);
   assign clear_xfer   = req_valid && req_ready && (req_func == fpba_pkg::FUNC_CLEAR);
   assign clear_ok     = rsp_valid && (rsp_status == fpba_pkg::STATUS_DONE) && rsp_zero;

   // Hold a stalled result
   `FPBA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall,
      rsp_valid && $stable(rsp_payload), "stalled result changed")

   // Status carries only defined codes
   `FPBA_ASSERT_NOW(a_status_code, clock, reset, rsp_valid, status_known,
      "undefined status code")

   // Failed transfers report no block and no leftover
   `FPBA_ASSERT_NOW(a_fail_zero, clock, reset, rsp_fail, rsp_zero,
      "failure result not zeroed")

   // Clear answers in the next cycle with a plain done
   `FPBA_ASSERT_NEXT(a_clear_result, clock, reset, clear_xfer, clear_ok,
      "clear result wrong or late")

endmodule

bind fit_policy_block_allocator fpba_checker u_fpba_checker (.*);

### verif/testbench.sv
// Self-checking testbench for the fit-policy block allocator: directed rows, then random traffic.
// Depends on fpba_pkg and fit_policy_block_allocator; every result is checked against a local model or a fixed row.
module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_BLOCKS   = 32;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int SEGMENTS     = 12;
   localparam int SEG_ITEMS    = 92;

   // Codes without a meaning of their own; the block treats them as defined fallbacks
   localparam logic [1:0] FUNC_UNUSED   = 2'd3;
   localparam logic [1:0] POLICY_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]  status;
      logic [4:0]  index;
      logic [15:0] leftover;
   } alloc_result_type;

   typedef struct packed {
      logic [1:0]       policy;
      logic [1:0]       func;
      logic [15:0]      size;
      logic [5:0]       reps;
      logic             fixed;
      alloc_result_type want;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_fit_policy;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_func;
   logic [15:0] req_size_value;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_status;
   logic [4:0]  rsp_block_index;
   logic [15:0] rsp_leftover;

   // Local copy of the allocation table and the policy register
   logic [15:0] tbl_size [MAX_BLOCKS];
   logic        tbl_used [MAX_BLOCKS];
   int          tbl_count;
   logic [1:0]  cur_policy;

   alloc_result_type pending_results[$];
   stim_row_type     stim_rows[$];

   int send_idle_pct;
   int rsp_idle_pct;
   int cycle_count;
   int mismatch_count;
   int results_checked;
   int items_sent;
   int policy_writes;
   int placements_done;
   int no_fit_count;
   int full_count;

   fit_policy_block_allocator #(
      .MAX_BLOCKS(MAX_BLOCKS)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_fit_policy (csr_fit_policy),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_size_value (req_size_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_block_index(rsp_block_index),
      .rsp_leftover   (rsp_leftover)
   );

   // Free-running clock, 4 ns period
   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Advance the cycle counter and stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still pending",
                  cycle_count, pending_results.size());
         $display("testbench failed");
         $finish;
      end
   end

   // Stall the result channel at random
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   // Compute the result of one item and update the table copy
   function automatic alloc_result_type predict_allocation(logic [1:0] func,
                                                           logic [15:0] size);
      alloc_result_type res;
      logic             found;
      int               pick;
      res   = '0;
      found = 1'b0;
      pick  = 0;
      if (func == fpba_pkg::FUNC_LOAD) begin
         if (tbl_count >= MAX_BLOCKS) begin
            res.status = fpba_pkg::STATUS_FULL;
         end else begin
            tbl_size[tbl_count] = size;
            tbl_used[tbl_count] = 1'b0;
            res.status = fpba_pkg::STATUS_DONE;
            res.index  = 5'(tbl_count);
            tbl_count++;
         end
      end else if (func == fpba_pkg::FUNC_REQUEST) begin
         for (int j = 0; j < tbl_count; j++) begin
            if (!tbl_used[j] && size <= tbl_size[j]) begin
               if (!found) begin
                  found = 1'b1;
                  pick  = j;
                  if (cur_policy != fpba_pkg::POLICY_BEST &&
                      cur_policy != fpba_pkg::POLICY_WORST) break;
               end else if (cur_policy == fpba_pkg::POLICY_BEST) begin
                  if (tbl_size[j] < tbl_size[pick]) pick = j;
               end else if (cur_policy == fpba_pkg::POLICY_WORST) begin
                  if (tbl_size[j] > tbl_size[pick]) pick = j;
               end
            end
         end
         if (!found) begin
            res.status = fpba_pkg::STATUS_NO_FIT;
         end else begin
            tbl_size[pick] = tbl_size[pick] - size;
            tbl_used[pick] = 1'b1;
            res.status   = fpba_pkg::STATUS_DONE;
            res.index    = 5'(pick);
            res.leftover = tbl_size[pick];
         end
      end else if (func == fpba_pkg::FUNC_CLEAR) begin
         tbl_count = 0;
         for (int j = 0; j < MAX_BLOCKS; j++) tbl_used[j] = 1'b0;
      end
      return res;
   endfunction

   task automatic report_mismatch(string what, alloc_result_type want, alloc_result_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("cycle %0d: %s: expected status %0d index %0d leftover %0d, got %0d %0d %0d",
                  cycle_count, what, want.status, want.index, want.leftover,
                  got.status, got.index, got.leftover);
      end
   endtask

   // Compare every result transfer with the oldest expectation
   always @(posedge clock) begin : rsp_check
      alloc_result_type got;
      alloc_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_status, rsp_block_index, rsp_leftover};
         if (pending_results.size() == 0) begin
            report_mismatch("result with nothing pending", '0, got);
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (got !== want) report_mismatch("result mismatch", want, got);
         end
      end
   end

   // Offer one item, hold it until the transfer, then record its expectation
   task automatic send_item(logic [1:0] func, logic [15:0] size, logic fixed,
                            alloc_result_type want);
      alloc_result_type res;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= func;
      req_size_value <= size;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      res = predict_allocation(func, size);
      pending_results.push_back(fixed ? want : res);
      items_sent++;
      if (func == fpba_pkg::FUNC_REQUEST && res.status == fpba_pkg::STATUS_DONE) begin
         placements_done++;
      end
      if (res.status == fpba_pkg::STATUS_NO_FIT) no_fit_count++;
      if (res.status == fpba_pkg::STATUS_FULL) full_count++;
      @(negedge clock);
   endtask

   // Hold the sender until every pending result has drained
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_results.size() != 0);
   endtask

   // Write the policy register while the block is idle
   task automatic write_policy(logic [1:0] value);
      drain_results();
      repeat (4) @(negedge clock);
      csr_valid      <= 1'b1;
      csr_fit_policy <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      cur_policy = value;
      policy_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic add_row(logic [1:0] policy, logic [1:0] func, logic [15:0] size,
                          logic [5:0] reps, logic fixed, logic [1:0] st,
                          logic [4:0] idx, logic [15:0] left);
      stim_row_type row;
      row.policy = policy;
      row.func   = func;
      row.size   = size;
      row.reps   = reps;
      row.fixed  = fixed;
      row.want   = '{st, idx, left};
      stim_rows.push_back(row);
   endtask

   // Pick a random item, mostly loads and requests shaped by the table contents
   task automatic random_item(output logic [1:0] func, output logic [15:0] size);
      int r;
      int k;
      int j;
      r = $urandom_range(0, 199);
      k = $urandom_range(0, 9);
      if (r < 3) begin
         func = FUNC_UNUSED;
         size = 16'($urandom);
      end else if (r < 6) begin
         func = fpba_pkg::FUNC_CLEAR;
         size = 16'($urandom);
      end else if (r < 6 + ((tbl_count < 4) ? 120 : 70)) begin
         func = fpba_pkg::FUNC_LOAD;
         case (k)
            0: size = 16'd0;
            1: size = 16'hFFFF;
            2, 3: size = 16'($urandom);
            default: size = 16'($urandom_range(1, 16) * 64);
         endcase
      end else begin
         func = fpba_pkg::FUNC_REQUEST;
         case (k)
            0: size = 16'd0;
            1: size = 16'hFFFF;
            2: size = 16'($urandom);
            3, 4, 5, 6: begin
               if (tbl_count > 0) begin
                  j = $urandom_range(0, tbl_count - 1);
                  r = $urandom_range(0, 2);
                  size = (tbl_size[j] > 16'(r)) ? tbl_size[j] - 16'(r) : 16'd0;
               end else begin
                  size = 16'($urandom_range(0, 1023));
               end
            end
            default: size = 16'($urandom_range(0, 1023));
         endcase
      end
   endtask

   initial begin : stimulus
      stim_row_type row;
      logic [1:0]   func;
      logic [15:0]  size;
      logic         first_row;

      reset          = 1'b1;
      csr_valid      = 1'b0;
      csr_fit_policy = fpba_pkg::POLICY_FIRST;
      req_valid      = 1'b0;
      req_func       = fpba_pkg::FUNC_LOAD;
      req_size_value = '0;
      rsp_ready      = 1'b0;
      cycle_count    = 0;
      mismatch_count = 0;
      results_checked = 0;
      items_sent     = 0;
      policy_writes  = 0;
      placements_done = 0;
      no_fit_count   = 0;
      full_count     = 0;
      tbl_count      = 0;
      cur_policy     = fpba_pkg::POLICY_FIRST;
      for (int j = 0; j < MAX_BLOCKS; j++) begin
         tbl_size[j] = '0;
         tbl_used[j] = 1'b0;
      end
      send_idle_pct = 37;
      rsp_idle_pct  = 58;

      // Directed rows: empty table, unused func, size extremes, each policy, full table
      add_row(fpba_pkg::POLICY_FIRST, fpba_pkg::FUNC_REQUEST, 16'd0, 6'd1, 1'b1,
              fpba_pkg::STATUS_NO_FIT, 5'd0, 16'd0);
      add_row(fpba_pkg::POLICY_FIRST, FUNC_UNUSED, 16'hFFFF, 6'd1, 1'b1,
              fpba_pkg::STATUS_DONE, 5'd0, 16'd0);
      add_row(fpba_pkg::POLICY_FIRST, fpba_pkg::FUNC_LOAD, 16'd0, 6'd1, 1'b1,
              fpba_pkg::STATUS_DONE, 5'd0, 16'd0);
      add_row(fpba_pkg::POLICY_FIRST, fpba_pkg::FUNC_LOAD, 16'hFFFF, 6'd1, 1'b1,
              fpba_pkg::STATUS_DONE, 5'd1, 16'd0);
      add_row(fpba_pkg::POLICY_FIRST, fpba_pkg::FUNC_LOAD, 16'd100, 6'd1, 1'b1,
              fpba_pkg::STATUS_DONE, 5'd2, 16'd0);
      add_row(fpba_pkg::POLICY_FIRST, fpba_pkg::FUNC_LOAD, 16'd100, 6'd1, 1'b1,
              fpba_pkg::STATUS_DONE, 5'd3, 16'd0);
      add_row(fpba_pkg::POLICY_FIRST, fpba_pkg::FUNC_REQUEST, 16'd0, 6'd1, 1'b1,
              fpba_pkg::STATUS_DONE, 5'd0, 16'd0);
      add_row(fpba_pkg::POLICY_FIRST, fpba_pkg::FUNC_REQUEST, 16'hFFFF, 6'd1, 1'b1,
              fpba_pkg::STATUS_DONE, 5'd1, 16'd0);
      add_row(fpba_pkg::POLICY_FIRST, fpba_pkg::FUNC_REQUEST, 16'd1, 6'd1, 1'b1,
              fpba_pkg::STATUS_DONE, 5'd2, 16'd99);
      add_row(fpba_pkg::POLICY_BEST, fpba_pkg::FUNC_LOAD, 16'd50, 6'd1, 1'b1,
              fpba_pkg::STATUS_DONE, 5'd4, 16'd0);
      add_row(fpba_pkg::POLICY_BEST, fpba_pkg::FUNC_REQUEST, 16'd40, 6'd1, 1'b0,
              fpba_pkg::STATUS_DONE, 5'd0, 16'd0);
      add_row(fpba_pkg::POLICY_BEST, fpba_pkg::FUNC_REQUEST, 16'd101, 6'd1, 1'b1,
              fpba_pkg::STATUS_NO_FIT, 5'd0, 16'd0);
      add_row(fpba_pkg::POLICY_WORST, fpba_pkg::FUNC_LOAD, 16'd200, 6'd1, 1'b1,
              fpba_pkg::STATUS_DONE, 5'd5, 16'd0);
      add_row(fpba_pkg::POLICY_WORST, fpba_pkg::FUNC_REQUEST, 16'd5, 6'd1, 1'b0,
              fpba_pkg::STATUS_DONE, 5'd0, 16'd0);
      add_row(POLICY_UNUSED, fpba_pkg::FUNC_REQUEST, 16'd5, 6'd1, 1'b0,
              fpba_pkg::STATUS_DONE, 5'd0, 16'd0);
      add_row(POLICY_UNUSED, fpba_pkg::FUNC_CLEAR, 16'd7, 6'd1, 1'b1,
              fpba_pkg::STATUS_DONE, 5'd0, 16'd0);
      add_row(fpba_pkg::POLICY_FIRST, fpba_pkg::FUNC_LOAD, 16'd7, 6'd32, 1'b0,
              fpba_pkg::STATUS_DONE, 5'd0, 16'd0);
      add_row(fpba_pkg::POLICY_FIRST, fpba_pkg::FUNC_LOAD, 16'd9, 6'd1, 1'b1,
              fpba_pkg::STATUS_FULL, 5'd0, 16'd0);
      add_row(fpba_pkg::POLICY_WORST, fpba_pkg::FUNC_REQUEST, 16'd7, 6'd1, 1'b1,
              fpba_pkg::STATUS_DONE, 5'd0, 16'd0);
      add_row(fpba_pkg::POLICY_WORST, fpba_pkg::FUNC_REQUEST, 16'hFFFF, 6'd1, 1'b1,
              fpba_pkg::STATUS_NO_FIT, 5'd0, 16'd0);
      add_row(fpba_pkg::POLICY_BEST, fpba_pkg::FUNC_REQUEST, 16'd3, 6'd1, 1'b0,
              fpba_pkg::STATUS_DONE, 5'd0, 16'd0);
      add_row(fpba_pkg::POLICY_BEST, fpba_pkg::FUNC_CLEAR, 16'd0, 6'd1, 1'b1,
              fpba_pkg::STATUS_DONE, 5'd0, 16'd0);

      // Release reset on a falling clock edge
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Walk the directed rows, writing the policy wherever a row changes it
      first_row = 1'b1;
      foreach (stim_rows[i]) begin
         row = stim_rows[i];
         if (first_row || row.policy != cur_policy) write_policy(row.policy);
         first_row = 1'b0;
         for (int n = 0; n < row.reps; n++) send_item(row.func, row.size, row.fixed, row.want);
      end

      // Random segments: idle mix by third of the run, every policy in each third
      for (int s = 0; s < SEGMENTS; s++) begin
         write_policy(2'(s % 4));
         case (s / 4)
            0: begin send_idle_pct = 37; rsp_idle_pct = 58; end
            1: begin send_idle_pct = 58; rsp_idle_pct = 37; end
            default: begin send_idle_pct = 0; rsp_idle_pct = 0; end
         endcase
         for (int n = 0; n < SEG_ITEMS; n++) begin
            if ($urandom_range(0, 39) == 0) drain_results();
            random_item(func, size);
            send_item(func, size, 1'b0, '0);
         end
      end

      // Drain, then give the block time to show any stray result
      drain_results();
      repeat (MAX_BLOCKS + 8) @(posedge clock);

      $display("sent %0d items over %0d policy writes, checked %0d results",
               items_sent, policy_writes, results_checked);
      $display("placements %0d, no-fit %0d, table-full %0d, mismatches %0d",
               placements_done, no_fit_count, full_count, mismatch_count);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

### files.f
+incdir+hdl
hdl/fpba_pkg.sv
hdl/fpba_ram.sv
hdl/fit_policy_block_allocator.sv
hdl/fpba_checker.sv
verif/testbench.sv
